// ===== design/mpis_pkg.sv =====
// ----------------------------------------------------------------------------
// mpis_pkg: moon phase icon shader shared definitions
// Icon geometry, fixed point widths, register indexes and the chord and
// cosine tables used by the shading datapath.
// ----------------------------------------------------------------------------
package mpis_pkg;

    // icon geometry
    localparam int ICON_SIZE = 32;
    localparam int CENTRE_X  = 16;
    localparam int CENTRE_Y  = 14;
    localparam int RADIUS    = 14;
    localparam int FRAC_BITS = 12;
    localparam int MARK_X    = 20;
    localparam int MARK_Y    = 14;

    // port widths
    localparam int COL_W      = 5;
    localparam int ROW_W      = 5;
    localparam int PIX_W      = 8;
    localparam int PHASE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // datapath widths
    localparam int CP_W     = FRAC_BITS + 7;          // chord half-width, Q.F
    localparam int CS_W     = FRAC_BITS + 2;          // signed cosine, Q.F
    localparam int S_W      = 2 * FRAC_BITS + 10;     // span sums at scale 2^2F
    localparam int TR_W     = S_W - 2 * FRAC_BITS;    // integer span ends
    localparam int X_W      = FRAC_BITS + 8;          // column compare at scale 2^F
    localparam int CP_IDX_W = (RADIUS > 1) ? $clog2(RADIUS) : 1;
    localparam int ROW_D_W  = ROW_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE    = 3'd0,
        CFG_DARK     = 3'd1,
        CFG_CLEAR    = 3'd2,
        CFG_MARK_COL = 3'd3,
        CFG_MARK_EN  = 3'd4
    } t_cfg_idx;

    typedef logic [16:0] t_cos_tab [0:16];
    typedef logic [CP_W-1:0] t_chord_tab [0:RADIUS-1];

    // cos(k*pi/32) in Q16
    localparam t_cos_tab COS_Q16 = '{
        17'd65536, 17'd65220, 17'd64277, 17'd62714, 17'd60547, 17'd57798,
        17'd54491, 17'd50660, 17'd46341, 17'd41576, 17'd36410, 17'd30893,
        17'd25080, 17'd19024, 17'd12785, 17'd6424,  17'd0
    };

    // floor(sqrt((R^2 - i^2) * 2^2F)) for every disc row, built at elaboration
    function automatic t_chord_tab build_chord_tab();
        t_chord_tab          tab;
        longint unsigned     n;
        longint unsigned     r;
        longint unsigned     b;
        for (int i = 0; i < RADIUS; i++) begin
            n = longint'(RADIUS * RADIUS - i * i) << (2 * FRAC_BITS);
            r = 0;
            for (int j = 0; j < 32; j++) begin
                b = 64'd1 << (62 - 2 * j);
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
            end
            tab[i] = r[CP_W-1:0];
        end
        return tab;
    endfunction

    localparam t_chord_tab CHORD_TAB = build_chord_tab();

endpackage

// ===== design/moon_phase_icon_shader.sv =====
// ----------------------------------------------------------------------------
// moon_phase_icon_shader: per-pixel lunar phase shading of a moon icon
// Shades template pixels outside the lit span of each disc row and draws
// the optional mark pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel channel: i_valid/o_ready carry column, row and template value.
//   Result channel: o_valid/i_ready carry the shaded value, one result per
//   pixel, in input order.
//   Config channel: i_cfg_valid/o_cfg_ready write register i_cfg_index
//   (0 phase, 1 dark colour, 2 clear colour, 3 mark colour, 4 mark enable);
//   o_cfg_ready is always high and other indexes are ignored. Write only
//   while no pixel is in flight.
//   Each pixel passes through an input register, then the chord lookup,
//   one cosine-by-chord multiply and the span compares into the result
//   register. One pixel per cycle sustained while the receiver is ready.
//   The cosine for the phase is worked out when the phase is written.
//   Reset clears both pipeline stages and sets the config registers to
//   zero, but for the cosine, which resets to 1.0.
//   When the receiver stalls, the result holds and the input register
//   keeps accepting until it holds an item too.
// ----------------------------------------------------------------------------
module moon_phase_icon_shader (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // pixel in
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [mpis_pkg::COL_W-1:0]        i_pixel_column,
    input  logic [mpis_pkg::ROW_W-1:0]        i_pixel_row,
    input  logic [mpis_pkg::PIX_W-1:0]        i_template_value,
    // pixel out
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [mpis_pkg::PIX_W-1:0]        o_shaded_value,
    // config
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mpis_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mpis_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int F    = mpis_pkg::FRAC_BITS;
    localparam int S_W  = mpis_pkg::S_W;
    localparam int TR_W = mpis_pkg::TR_W;
    localparam int X_W  = mpis_pkg::X_W;
    localparam int CP_W = mpis_pkg::CP_W;
    localparam int CS_W = mpis_pkg::CS_W;

    // config registers
    logic                              r_half;      // phase >= 1/2
    logic signed [CS_W-1:0]            r_cos;
    logic [mpis_pkg::PIX_W-1:0]        r_dark;
    logic [mpis_pkg::PIX_W-1:0]        r_clear;
    logic [mpis_pkg::PIX_W-1:0]        r_mark;
    logic                              r_mark_en;

    // pipeline registers
    logic                              r_s1_valid;
    logic [mpis_pkg::COL_W-1:0]        r_col;
    logic [mpis_pkg::ROW_W-1:0]        r_row;
    logic [mpis_pkg::PIX_W-1:0]        r_tmpl;
    logic                              r_out_valid;
    logic [mpis_pkg::PIX_W-1:0]        r_shaded;
    logic [mpis_pkg::PIX_W-1:0]        n_shaded;

    logic                              s1_advance;
    logic                              in_xfer;
    logic                              cfg_xfer;

    // cosine of the written phase
    logic [1:0]                        cq;
    logic [13:0]                       cu;
    logic [14:0]                       ca;
    logic [3:0]                        ck;
    logic [9:0]                        cf;
    logic [16:0]                       ct0;
    logic [16:0]                       ct1;
    logic [26:0]                       cprod;
    logic [27:0]                       cm;
    logic [27:0]                       cm_sh;
    logic [F:0]                        cmag;
    logic signed [CS_W-1:0]            n_cos;

    // shading datapath
    logic signed [mpis_pkg::ROW_D_W-1:0] d;
    logic signed [mpis_pkg::ROW_D_W-1:0] di;
    logic                              in_disc;
    logic [mpis_pkg::CP_IDX_W-1:0]     cp_idx;
    logic [CP_W-1:0]                   cp;
    logic signed [S_W-1:0]             prod;
    logic signed [S_W-1:0]             cpf;
    logic signed [S_W-1:0]             cx2;
    logic signed [S_W-1:0]             s_l;
    logic signed [S_W-1:0]             s_r;
    logic signed [TR_W-1:0]            lx;
    logic signed [TR_W-1:0]            rx;
    logic signed [TR_W-1:0]            xe;
    logic signed [TR_W:0]              rx_p1;
    logic                              right_ok;
    logic                              shade;
    logic signed [X_W-1:0]             xs;
    logic signed [X_W-1:0]             cxf;
    logic signed [X_W-1:0]             cpx;
    logic                              in_circle;
    logic                              mark_hit;

    function automatic logic signed [TR_W-1:0] trunc2f(input logic signed [S_W-1:0] s);
        logic [S_W-1:0] mag;
        logic [S_W-1:0] q;
        logic [S_W-1:0] res;
        mag = s[S_W-1] ? (~s + 1'b1) : s;
        q   = mag >> (2 * F);
        res = s[S_W-1] ? (~q + 1'b1) : q;
        return $signed(res[TR_W-1:0]);
    endfunction

    // handshakes
    assign s1_advance  = !r_out_valid || i_ready;
    assign o_ready     = !r_s1_valid || s1_advance;
    assign in_xfer     = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign o_valid        = r_out_valid;
    assign o_shaded_value = r_shaded;

    // quarter-wave cosine with linear interpolation, rounded to Q.F
    always_comb begin
        cq    = i_cfg_data[15:14];
        cu    = i_cfg_data[13:0];
        ca    = cq[0] ? (15'd16384 - {1'b0, cu}) : {1'b0, cu};
        ck    = ca[13:10];
        cf    = ca[9:0];
        ct0   = mpis_pkg::COS_Q16[{1'b0, ck}];
        ct1   = mpis_pkg::COS_Q16[{1'b0, ck} + 5'd1];
        cprod = 27'(ct0 - ct1) * 27'(cf);
        if (ca[14]) begin
            cm = '0;
        end else begin
            cm = {1'b0, ct0, 10'd0} - {1'b0, cprod};
        end
        cm_sh = (cm + (28'd1 << (25 - F))) >> (26 - F);
        cmag  = cm_sh[F:0];
        if (cq == 2'd1 || cq == 2'd2) begin
            n_cos = -$signed({1'b0, cmag});
        end else begin
            n_cos = $signed({1'b0, cmag});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half    <= 1'b0;
            r_cos     <= $signed(CS_W'(1) << F);
            r_dark    <= '0;
            r_clear   <= '0;
            r_mark    <= '0;
            r_mark_en <= 1'b0;
        end else if (cfg_xfer) begin
            unique case (i_cfg_index)
                mpis_pkg::CFG_PHASE: begin
                    r_half <= i_cfg_data[mpis_pkg::PHASE_W-1];
                    r_cos  <= n_cos;
                end
                mpis_pkg::CFG_DARK:     r_dark    <= i_cfg_data[mpis_pkg::PIX_W-1:0];
                mpis_pkg::CFG_CLEAR:    r_clear   <= i_cfg_data[mpis_pkg::PIX_W-1:0];
                mpis_pkg::CFG_MARK_COL: r_mark    <= i_cfg_data[mpis_pkg::PIX_W-1:0];
                mpis_pkg::CFG_MARK_EN:  r_mark_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // span of the row and the shading decision
    always_comb begin
        d       = $signed({2'b00, r_row}) - $signed(mpis_pkg::ROW_D_W'(mpis_pkg::CENTRE_Y));
        di      = d[mpis_pkg::ROW_D_W-1] ? -d : d;
        in_disc = di < $signed(mpis_pkg::ROW_D_W'(mpis_pkg::RADIUS));
        cp_idx  = in_disc ? di[mpis_pkg::CP_IDX_W-1:0] : '0;
        cp      = mpis_pkg::CHORD_TAB[cp_idx];

        prod = r_cos * $signed({1'b0, cp});
        cpf  = $signed({3'b000, cp, {F{1'b0}}});
        cx2  = $signed(S_W'(mpis_pkg::CENTRE_X) << (2 * F));
        if (!r_half) begin
            s_r = cx2 + cpf;
            s_l = cx2 + prod;
        end else begin
            s_l = cx2 - cpf;
            s_r = cx2 - prod;
        end
        lx = trunc2f(s_l);
        rx = trunc2f(s_r);

        rx_p1    = $signed({rx[TR_W-1], rx}) + $signed((TR_W + 1)'(1));
        right_ok = rx_p1 < $signed((TR_W + 1)'(mpis_pkg::ICON_SIZE));
        xe       = $signed({{(TR_W - mpis_pkg::COL_W){1'b0}}, r_col});

        shade = 1'b0;
        if (in_disc && !lx[TR_W-1] && (lx != '0)
            && ({1'b0, r_col} < (mpis_pkg::COL_W + 1)'(mpis_pkg::ICON_SIZE))) begin
            if (!d[mpis_pkg::ROW_D_W-1]) begin
                shade = (xe < lx) || (right_ok && (xe > rx));
            end else begin
                shade = right_ok && ((xe < lx) || (xe > rx));
            end
        end

        xs        = $signed({{(X_W - mpis_pkg::COL_W - F){1'b0}}, r_col, {F{1'b0}}});
        cxf       = $signed(X_W'(mpis_pkg::CENTRE_X) << F);
        cpx       = $signed({{(X_W - CP_W){1'b0}}, cp});
        in_circle = (xs >= cxf - cpx) && (xs <= cxf + cpx);

        mark_hit = r_mark_en
                   && (r_col == mpis_pkg::COL_W'(mpis_pkg::MARK_X))
                   && (r_row == mpis_pkg::ROW_W'(mpis_pkg::MARK_Y));

        priority if (mark_hit) begin
            n_shaded = r_mark;
        end else if (shade) begin
            n_shaded = in_circle ? r_dark : r_clear;
        end else begin
            n_shaded = r_tmpl;
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s1_advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_col  <= i_pixel_column;
            r_row  <= i_pixel_row;
            r_tmpl <= i_template_value;
        end
        if (s1_advance && r_s1_valid) begin
            r_shaded <= n_shaded;
        end
    end

endmodule
